[rtl/line_line_closest_approach_defines.svh]
// ----------------------------------------------------------------------------
// line_line_closest_approach_defines
// assertion macros used by the closest approach rtl
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_CLOSEST_APPROACH_DEFINES_SVH
`define LINE_LINE_CLOSEST_APPROACH_DEFINES_SVH

// same-cycle implication on clk, disabled in reset
`define LLCA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("llca assertion failed");

// implication with a fixed delay
`define LLCA_ASSERT_DLY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("llca delayed assertion failed");

`endif

[rtl/llca_pkg.sv]
// ----------------------------------------------------------------------------
// llca_pkg
// types and constants of the line to line closest approach block
// ----------------------------------------------------------------------------
package llca_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 12;
	localparam int T_SHIFT    = 16;
	localparam int OUT_W      = 32;
	localparam int THR_W      = 16;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_W-1:0] tparam_t;

	typedef struct packed {
		coord_t a_point_x;
		coord_t a_point_y;
		coord_t a_point_z;
		coord_t a_dir_x;
		coord_t a_dir_y;
		coord_t a_dir_z;
		coord_t b_point_x;
		coord_t b_point_y;
		coord_t b_point_z;
		coord_t b_dir_x;
		coord_t b_dir_y;
		coord_t b_dir_z;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] distance;
		tparam_t          t_a;
		tparam_t          t_b;
		logic             parallel;
		logic             degenerate;
	} out_t;

endpackage

[rtl/llca_mul.sv]
// ----------------------------------------------------------------------------
// llca_mul
// two stage signed multiplier built from four half width partial products
// ----------------------------------------------------------------------------
module llca_mul #(
	parameter int AW = 51,
	parameter int BW = 51
) (
	input  logic                 clk,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	localparam int MAXW = (AW > BW) ? AW : BW;
	localparam int H    = (MAXW + 1) / 2;
	localparam int TW   = 4 * H + 2;

	logic signed [2*H-1:0] ax, bx;
	logic [H-1:0]          alo, blo;
	logic signed [H-1:0]   ahi, bhi;

	logic [2*H-1:0]        ll_s1;
	logic signed [2*H:0]   lh_s1, hl_s1;
	logic signed [2*H-1:0] hh_s1;
	logic signed [TW-1:0]  sum;
	logic signed [AW+BW-1:0] p_s2;

	assign ax  = (2*H)'(a);
	assign bx  = (2*H)'(b);
	assign alo = ax[H-1:0];
	assign blo = bx[H-1:0];
	assign ahi = ax[2*H-1:H];
	assign bhi = bx[2*H-1:H];

	always_ff @(posedge clk) begin
		ll_s1 <= alo * blo;
		lh_s1 <= $signed({1'b0, alo}) * bhi;
		hl_s1 <= ahi * $signed({1'b0, blo});
		hh_s1 <= ahi * bhi;
	end

	assign sum = (TW'(hh_s1) <<< (2*H)) + (TW'(lh_s1) <<< H) + (TW'(hl_s1) <<< H)
		+ $signed(TW'(ll_s1));

	always_ff @(posedge clk) begin
		p_s2 <= (AW+BW)'(sum);
	end

	assign p = p_s2;

endmodule

[rtl/llca_div.sv]
// ----------------------------------------------------------------------------
// llca_div
// pipelined signed divider, quotient scaled by 2^16, truncated and saturated
// ----------------------------------------------------------------------------
module llca_div #(
	parameter int NW    = 103,
	parameter int TAG_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [NW-1:0]          num,
	input  logic signed [NW-1:0]          den,
	input  logic [TAG_W-1:0]              in_tag,
	output logic                          out_vld,
	output logic signed [llca_pkg::OUT_W-1:0] quot,
	output logic                          flag,
	output logic [TAG_W-1:0]              out_tag
);
	import llca_pkg::*;

	localparam int QB = OUT_W;
	localparam int XW = NW + QB + 1;
	localparam logic [QB-1:0] SAT_POS = {1'b0, {(QB-1){1'b1}}};
	localparam logic [QB-1:0] SAT_NEG = {1'b1, {(QB-1){1'b0}}};

	logic             vld_s  [0:QB];
	logic             neg_s  [0:QB];
	logic             zero_s [0:QB];
	logic             big_s  [0:QB];
	logic [XW-1:0]    rem_s  [0:QB];
	logic [NW-1:0]    dm_s   [0:QB];
	logic [QB-1:0]    q_s    [0:QB];
	logic [TAG_W-1:0] tag_s  [0:QB];

	logic [NW-1:0] nmag, dmag;
	logic [XW-1:0] rem0;
	logic          ovf;
	logic          vld_out_q;
	logic [QB-1:0] quot_q;
	logic          flag_q;
	logic [TAG_W-1:0] tag_q;

	assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
	assign dmag = den[NW-1] ? NW'(-den) : NW'(den);
	assign rem0 = XW'(nmag) << T_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0]  <= num[NW-1] ^ den[NW-1];
		zero_s[0] <= (den == '0);
		big_s[0]  <= rem0 >= (XW'(dmag) << QB);
		rem_s[0]  <= rem0;
		dm_s[0]   <= dmag;
		q_s[0]    <= '0;
		tag_s[0]  <= in_tag;
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [XW-1:0] trial;
		logic          ge;

		assign trial = XW'(dm_s[k-1]) << (QB - k);
		assign ge    = rem_s[k-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? rem_s[k-1] - trial : rem_s[k-1];
			q_s[k]    <= {q_s[k-1][QB-2:0], ge};
			neg_s[k]  <= neg_s[k-1];
			zero_s[k] <= zero_s[k-1];
			big_s[k]  <= big_s[k-1];
			dm_s[k]   <= dm_s[k-1];
			tag_s[k]  <= tag_s[k-1];
		end
	end

	assign ovf = big_s[QB] | (neg_s[QB] ? (q_s[QB][QB-1] & (|q_s[QB][QB-2:0]))
		: q_s[QB][QB-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else begin
			vld_out_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= tag_s[QB];
		priority if (zero_s[QB]) begin
			quot_q <= '0;
			flag_q <= 1'b1;
		end else if (ovf) begin
			quot_q <= neg_s[QB] ? SAT_NEG : SAT_POS;
			flag_q <= 1'b1;
		end else begin
			quot_q <= neg_s[QB] ? QB'(-q_s[QB]) : q_s[QB];
			flag_q <= 1'b0;
		end
	end

	assign out_vld = vld_out_q;
	assign quot    = $signed(quot_q);
	assign flag    = flag_q;
	assign out_tag = tag_q;

endmodule

[rtl/line_line_closest_approach.sv]
// ----------------------------------------------------------------------------
// line_line_closest_approach
// closest point parameters and distance of two 3d lines, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | ports                 | transfer
//  ---------+-----------------------+---------------------------------
//  item     | start, busy, item     | edge with start high, busy low
//  result   | done, result          | edge ending the cycle done is high
//  config   | wr_en, wr_data        | edge with wr_en high
//
//  one item per cycle, busy stays low; each result follows its item in order,
//  through the two 32 step dividers and the 32 step square root.
//  reset clears the valid bits and sets the threshold to 1.
//  the receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "line_line_closest_approach_defines.svh"

module line_line_closest_approach (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  llca_pkg::in_t               item,
	output logic                        done,
	output llca_pkg::out_t              result,
	input  logic                        wr_en,
	input  logic [llca_pkg::THR_W-1:0]  wr_data
);
	import llca_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int WW   = C + 1;
	localparam int PW   = 2 * C + 3;
	localparam int MW   = 2 * PW;
	localparam int NW   = MW + 1;
	localparam int GW   = 3 * WW + 6 * C;
	localparam int RW   = C + 34;
	localparam int SW   = 2 * RW + 2 - 2 * FRAC_BITS;
	localparam int TSW  = THR_W + 4 * FRAC_BITS + 1;
	localparam int CMPW = (NW + T_SHIFT + 1 > TSW) ? NW + T_SHIFT + 1 : TSW;
	localparam int SQN  = 32;
	localparam int MTW  = 2 * OUT_W + 3;
	localparam int LAT  = 80;

	logic [THR_W-1:0] thr_q;
	logic             accept;

	coord_t pa [3], ua [3], pb [3], ub [3];
	logic signed [WW-1:0] wc [3];
	logic [GW-1:0] gin;

	always_comb begin
		pa[0] = item.a_point_x; pa[1] = item.a_point_y; pa[2] = item.a_point_z;
		ua[0] = item.a_dir_x;   ua[1] = item.a_dir_y;   ua[2] = item.a_dir_z;
		pb[0] = item.b_point_x; pb[1] = item.b_point_y; pb[2] = item.b_point_z;
		ub[0] = item.b_dir_x;   ub[1] = item.b_dir_y;   ub[2] = item.b_dir_z;
	end

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (wr_en) begin
			thr_q <= wr_data;
		end
	end

	// geometry vector: w, dir a, dir b
	logic [GW-1:0] g_s1, g_s2, g_s3, g_s4, g_s5, g_s6, g_s7;
	logic signed [WW-1:0] w1 [3];
	logic signed [C-1:0]  u1 [3], v1 [3];

	for (genvar i = 0; i < 3; i++) begin : g_pack
		assign wc[i] = WW'(pa[i]) - WW'(pb[i]);
		assign gin[i*WW +: WW]          = wc[i];
		assign gin[3*WW + i*C +: C]     = ua[i];
		assign gin[3*WW + 3*C + i*C +: C] = ub[i];
		assign w1[i] = $signed(g_s1[i*WW +: WW]);
		assign u1[i] = $signed(g_s1[3*WW + i*C +: C]);
		assign v1[i] = $signed(g_s1[3*WW + 3*C + i*C +: C]);
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= accept; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
		end
	end

	// dot product terms
	logic signed [PW-1:0] uu_s2 [3], uv_s2 [3], vv_s2 [3], uw_s2 [3], vw_s2 [3];
	logic signed [PW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;
	logic signed [PW-1:0] b_s4, c_s4, d_s4, e_s4, b_s5, c_s5, d_s5, e_s5;
	logic signed [PW-1:0] b_s6, c_s6, d_s6, e_s6;

	always_ff @(posedge clk) begin
		g_s1 <= gin;
		for (int i = 0; i < 3; i++) begin
			uu_s2[i] <= PW'(u1[i]) * PW'(u1[i]);
			uv_s2[i] <= PW'(u1[i]) * PW'(v1[i]);
			vv_s2[i] <= PW'(v1[i]) * PW'(v1[i]);
			uw_s2[i] <= PW'(u1[i]) * PW'(w1[i]);
			vw_s2[i] <= PW'(v1[i]) * PW'(w1[i]);
		end
		g_s2 <= g_s1;
		a_s3 <= uu_s2[0] + uu_s2[1] + uu_s2[2];
		b_s3 <= uv_s2[0] + uv_s2[1] + uv_s2[2];
		c_s3 <= vv_s2[0] + vv_s2[1] + vv_s2[2];
		d_s3 <= uw_s2[0] + uw_s2[1] + uw_s2[2];
		e_s3 <= vw_s2[0] + vw_s2[1] + vw_s2[2];
		g_s3 <= g_s2;
		b_s4 <= b_s3; c_s4 <= c_s3; d_s4 <= d_s3; e_s4 <= e_s3; g_s4 <= g_s3;
		b_s5 <= b_s4; c_s5 <= c_s4; d_s5 <= d_s4; e_s5 <= e_s4; g_s5 <= g_s4;
		b_s6 <= b_s5; c_s6 <= c_s5; d_s6 <= d_s5; e_s6 <= e_s5; g_s6 <= g_s5;
	end

	logic signed [MW-1:0] ac, bb, be, cd, ae, bd;

	llca_mul #(.AW(PW), .BW(PW)) u_mul_ac (.clk(clk), .a(a_s3), .b(c_s3), .p(ac));
	llca_mul #(.AW(PW), .BW(PW)) u_mul_bb (.clk(clk), .a(b_s3), .b(b_s3), .p(bb));
	llca_mul #(.AW(PW), .BW(PW)) u_mul_be (.clk(clk), .a(b_s3), .b(e_s3), .p(be));
	llca_mul #(.AW(PW), .BW(PW)) u_mul_cd (.clk(clk), .a(c_s3), .b(d_s3), .p(cd));
	llca_mul #(.AW(PW), .BW(PW)) u_mul_ae (.clk(clk), .a(a_s3), .b(e_s3), .p(ae));
	llca_mul #(.AW(PW), .BW(PW)) u_mul_bd (.clk(clk), .a(b_s3), .b(d_s3), .p(bd));

	logic signed [NW-1:0] den_s6, na_s6, nb_s6;

	always_ff @(posedge clk) begin
		den_s6 <= NW'(ac) - NW'(bb);
		na_s6  <= NW'(be) - NW'(cd);
		nb_s6  <= NW'(ae) - NW'(bd);
	end

	// parallel decision and divider operands
	logic signed [CMPW-1:0] dsh, tsh;
	logic par, bgtc;
	logic signed [NW-1:0] numa_s7, dena_s7, numb_s7, denb_s7;
	logic par_s7;

	assign dsh  = CMPW'(den_s6) <<< T_SHIFT;
	assign tsh  = CMPW'(thr_q) << (4 * FRAC_BITS);
	assign par  = dsh < tsh;
	assign bgtc = b_s6 > c_s6;

	always_ff @(posedge clk) begin
		numa_s7 <= na_s6;
		dena_s7 <= den_s6;
		numb_s7 <= par ? NW'(bgtc ? d_s6 : e_s6) : nb_s6;
		denb_s7 <= par ? NW'(bgtc ? b_s6 : c_s6) : den_s6;
		par_s7  <= par;
		g_s7    <= g_s6;
	end

	tparam_t ta_raw, tb_raw;
	logic    fa, fb, par_d, vld_d, vld_da;
	logic [GW-1:0] g_d;

	llca_div #(.NW(NW), .TAG_W(1)) u_div_a (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s7), .num(numa_s7), .den(dena_s7),
		.in_tag(par_s7), .out_vld(vld_da), .quot(ta_raw), .flag(fa), .out_tag(par_d)
	);

	llca_div #(.NW(NW), .TAG_W(GW)) u_div_b (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s7), .num(numb_s7), .den(denb_s7),
		.in_tag(g_s7), .out_vld(vld_d), .quot(tb_raw), .flag(fb), .out_tag(g_d)
	);

	// residual vector between the closest points
	logic signed [WW-1:0] wd [3];
	logic signed [C-1:0]  ud [3], vd [3];
	tparam_t ta_sel;

	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign wd[i] = $signed(g_d[i*WW +: WW]);
		assign ud[i] = $signed(g_d[3*WW + i*C +: C]);
		assign vd[i] = $signed(g_d[3*WW + 3*C + i*C +: C]);
	end

	assign ta_sel = par_d ? '0 : ta_raw;

	logic signed [C+OUT_W-1:0] pu_s8 [3], pv_s8 [3];
	logic signed [WW+T_SHIFT-1:0] ws_s8 [3];
	logic signed [RW-1:0] r_s9 [3];
	logic [MTW-1:0] m_s8, m_s9, m_s10, m_s11, m_s12;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pu_s8[i] <= (C+OUT_W)'(ta_sel) * (C+OUT_W)'(ud[i]);
			pv_s8[i] <= (C+OUT_W)'(tb_raw) * (C+OUT_W)'(vd[i]);
			ws_s8[i] <= (WW+T_SHIFT)'(wd[i]) <<< T_SHIFT;
			r_s9[i]  <= RW'(ws_s8[i]) + RW'(pu_s8[i]) - RW'(pv_s8[i]);
		end
		m_s8  <= {ta_sel, tb_raw, par_d, fb | (~par_d & fa), 1'b0};
		m_s9  <= m_s8;
		m_s10 <= m_s9;
		m_s11 <= m_s10;
	end

	logic signed [2*RW-1:0] sq [3];

	for (genvar i = 0; i < 3; i++) begin : g_sq
		llca_mul #(.AW(RW), .BW(RW)) u_mul_sq (.clk(clk), .a(r_s9[i]), .b(r_s9[i]),
			.p(sq[i]));
	end

	logic signed [2*RW+1:0] ssum;
	logic [SW-1:0] s_s12;

	assign ssum = (2*RW+2)'(sq[0]) + (2*RW+2)'(sq[1]) + (2*RW+2)'(sq[2]);

	always_ff @(posedge clk) begin
		s_s12 <= SW'(ssum >> (2 * FRAC_BITS));
		m_s12 <= m_s11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0; vld_s9 <= 1'b0; vld_s10 <= 1'b0;
			vld_s11 <= 1'b0; vld_s12 <= 1'b0;
		end else begin
			vld_s8 <= vld_d; vld_s9 <= vld_s8; vld_s10 <= vld_s9;
			vld_s11 <= vld_s10; vld_s12 <= vld_s11;
		end
	end

	// square root, one result bit per stage
	logic [63:0]    sx_s [0:SQN];
	logic [63:0]    sr_s [0:SQN];
	logic [MTW-1:0] sm_s [0:SQN];
	logic           sv_s [0:SQN];
	logic           ssat;

	assign ssat = |s_s12[SW-1:64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s[0] <= 1'b0;
		end else begin
			sv_s[0] <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		sx_s[0] <= s_s12[63:0];
		sr_s[0] <= '0;
		sm_s[0] <= {m_s12[MTW-1:2], m_s12[1] | ssat, ssat};
	end

	for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
		logic [63:0] bitv, trial;
		logic        ge;

		assign bitv  = 64'(1) << (64 - 2 * k);
		assign trial = sr_s[k-1] + bitv;
		assign ge    = sx_s[k-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[k] <= 1'b0;
			end else begin
				sv_s[k] <= sv_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			sx_s[k] <= ge ? sx_s[k-1] - trial : sx_s[k-1];
			sr_s[k] <= ge ? (sr_s[k-1] >> 1) + bitv : sr_s[k-1] >> 1;
			sm_s[k] <= sm_s[k-1];
		end
	end

	out_t res_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sv_s[SQN];
		end
	end

	always_ff @(posedge clk) begin
		res_q.distance   <= sm_s[SQN][0] ? {OUT_W{1'b1}} : sr_s[SQN][OUT_W-1:0];
		res_q.t_a        <= $signed(sm_s[SQN][MTW-1 -: OUT_W]);
		res_q.t_b        <= $signed(sm_s[SQN][MTW-1-OUT_W -: OUT_W]);
		res_q.parallel   <= sm_s[SQN][2];
		res_q.degenerate <= sm_s[SQN][1];
	end

	assign done   = done_q;
	assign result = res_q;

	`LLCA_ASSERT_IMP(a_par_ta_zero, done && result.parallel, result.t_a == '0)
	`LLCA_ASSERT_IMP(a_div_lockstep, 1'b1, vld_da == vld_d)
	`LLCA_ASSERT_DLY(a_latency_fwd, accept, LAT, done)
	`LLCA_ASSERT_IMP(a_latency_bwd, done, $past(accept, LAT))

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks line_line_closest_approach against a bit exact predictor of the
// closest approach parameters, distance and flags, under bursty start
// traffic and several parallel thresholds
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import llca_pkg::*;

	typedef logic signed [255:0] wide_t;
	localparam int ONE = 1 << FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t item = '0;
	logic done;
	out_t result;
	logic wr_en = 1'b0;
	logic [THR_W-1:0] wr_data = '0;

	in_t pending_lines[$];
	out_t expected_closest[$];
	logic [THR_W-1:0] threshold = 1;
	int burst_left = 0;
	int gap_left = 0;
	int errors = 0;

	line_line_closest_approach dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .wr_en(wr_en), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	function automatic wide_t dot3(wide_t x0, wide_t x1, wide_t x2, wide_t y0, wide_t y1,
			wide_t y2);
		return x0 * y0 + x1 * y1 + x2 * y2;
	endfunction

	function automatic tparam_t div_q16_sat(wide_t num, wide_t den, inout bit flag);
		wide_t q;
		wide_t hi;
		wide_t lo;
		hi = 2**31 - 1;
		lo = -(wide_t'(1) <<< 31);
		if (den == 0) begin
			flag = 1'b1;
			return '0;
		end
		q = (num <<< T_SHIFT) / den;
		if (q > hi) begin
			flag = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (q < lo) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic logic [31:0] floor_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			cand = res | (64'd1 << i);
			if (cand * cand <= x)
				res = cand;
		end
		return res[31:0];
	endfunction

	function automatic out_t predict_closest(in_t it, logic [THR_W-1:0] thr);
		wide_t w[3];
		wide_t u[3];
		wide_t v[3];
		wide_t r[3];
		wide_t a, b, c, d, e, den, s, ta_w, tb_w, pu, pb, pv;
		tparam_t ta, tb;
		bit degen;
		bit par;
		out_t o;
		degen = 1'b0;
		pu = it.a_point_x; pb = it.b_point_x; w[0] = pu - pb;
		pu = it.a_point_y; pb = it.b_point_y; w[1] = pu - pb;
		pu = it.a_point_z; pb = it.b_point_z; w[2] = pu - pb;
		u[0] = it.a_dir_x; u[1] = it.a_dir_y; u[2] = it.a_dir_z;
		v[0] = it.b_dir_x; v[1] = it.b_dir_y; v[2] = it.b_dir_z;
		a = dot3(u[0], u[1], u[2], u[0], u[1], u[2]);
		b = dot3(u[0], u[1], u[2], v[0], v[1], v[2]);
		c = dot3(v[0], v[1], v[2], v[0], v[1], v[2]);
		d = dot3(u[0], u[1], u[2], w[0], w[1], w[2]);
		e = dot3(v[0], v[1], v[2], w[0], w[1], w[2]);
		den = a * c - b * b;
		pv = {240'd0, thr};
		par = (den <<< 16) < (pv <<< (4 * FRAC_BITS));
		if (par) begin
			ta = '0;
			if (b > c)
				tb = div_q16_sat(d, b, degen);
			else
				tb = div_q16_sat(e, c, degen);
		end else begin
			ta = div_q16_sat(b * e - c * d, den, degen);
			tb = div_q16_sat(a * e - b * d, den, degen);
		end
		ta_w = ta;
		tb_w = tb;
		for (int i = 0; i < 3; i++)
			r[i] = (w[i] <<< T_SHIFT) + ta_w * u[i] - tb_w * v[i];
		s = dot3(r[0], r[1], r[2], r[0], r[1], r[2]) >> (2 * FRAC_BITS);
		if ((s >> 64) != 0)
			degen = 1'b1;
		if (degen && (s >> 64) != 0)
			o.distance = 32'hFFFFFFFF;
		else
			o.distance = floor_sqrt(s[63:0]);
		o.t_a = ta;
		o.t_b = tb;
		o.parallel = par;
		o.degenerate = degen;
		return o;
	endfunction

	// item driver with bursts and gaps
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_closest.push_back(predict_closest(item, threshold));
		if (start && busy) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_lines.size() > 0 && arst_n) begin
			start <= 1'b1;
			item <= pending_lines.pop_front();
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && done) begin
			if (expected_closest.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				exp_r = expected_closest.pop_front();
				if (result.distance !== exp_r.distance) begin
					$error("distance exp %h got %h", exp_r.distance, result.distance);
					errors++;
				end
				if (result.t_a !== exp_r.t_a) begin
					$error("t_a exp %h got %h", exp_r.t_a, result.t_a);
					errors++;
				end
				if (result.t_b !== exp_r.t_b) begin
					$error("t_b exp %h got %h", exp_r.t_b, result.t_b);
					errors++;
				end
				if (result.parallel !== exp_r.parallel) begin
					$error("parallel exp %b got %b", exp_r.parallel, result.parallel);
					errors++;
				end
				if (result.degenerate !== exp_r.degenerate) begin
					$error("degenerate exp %b got %b", exp_r.degenerate, result.degenerate);
					errors++;
				end
			end
		end
	end

	function automatic coord_t rand_coord(int mode);
		case ($urandom_range(0, 9) < 2 ? 3 : mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
			2: return coord_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			default: begin
				case ($urandom_range(0, 3))
					0: return 24'sh7FFFFF;
					1: return 24'sh800000;
					2: return '0;
					default: return coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic in_t rand_lines();
		in_t it;
		int mode;
		int k;
		mode = $urandom_range(0, 2);
		it = '{rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode),
			rand_coord(mode), rand_coord(mode), rand_coord(mode)};
		case ($urandom_range(0, 7))
			0: begin
				// nearly parallel direction
				k = $urandom_range(0, 3);
				it.b_dir_x = (it.a_dir_x >>> k) + coord_t'($urandom_range(0, 2));
				it.b_dir_y = (it.a_dir_y >>> k);
				it.b_dir_z = (it.a_dir_z >>> k) - coord_t'($urandom_range(0, 2));
			end
			1: begin
				it.b_dir_x = -it.a_dir_x;
				it.b_dir_y = -it.a_dir_y;
				it.b_dir_z = -it.a_dir_z;
			end
			2: begin
				it.b_dir_x = '0;
				it.b_dir_y = '0;
				it.b_dir_z = '0;
			end
			default: begin
			end
		endcase
		return it;
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_lines.size() > 0 || start || expected_closest.size() > 0);
		repeat (90) @(posedge clk);
	endtask

	task automatic set_threshold(logic [THR_W-1:0] v);
		wait_idle();
		wr_en <= 1'b1;
		wr_data <= v;
		threshold = v;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_lines.push_back(rand_lines());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		pending_lines.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		pending_lines.push_back('{0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0, ONE, 0});
		pending_lines.push_back('{ONE, 2 * ONE, 3 * ONE, ONE, ONE, 0, 0, 0, 0, ONE, ONE, 0});
		pending_lines.push_back('{ONE, 0, 0, 4 * ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0});
		pending_lines.push_back('{ONE, 0, ONE, ONE, ONE, ONE, 0, 0, 0, 2 * ONE, 2 * ONE,
			2 * ONE});
		pending_lines.push_back('{ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		pending_lines.push_back('{ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0});
		pending_lines.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1, 0, 0,
			24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 1});
		pending_lines.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
			24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh800000,
			24'sh800000, 24'sh800000, 24'sh800000});
		pending_lines.push_back('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
			24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
			24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF});
		pending_lines.push_back('{-1, -1, -1, -1, 1, -1, 1, 1, 1, 1, -1, 1});
		pending_lines.push_back('{0, 0, 0, 24'sh800000, 0, 0, 0, 0, 0, 0, 24'sh7FFFFF, 0});
		pending_lines.push_back('{ONE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0});
		pending_lines.push_back('{5 * ONE, -3 * ONE, 7, 3, ONE, -ONE, -ONE, 2, 0, ONE, 3,
			-ONE});
		queue_random(100);
		set_threshold(0);
		pending_lines.push_back('{ONE, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0});
		pending_lines.push_back('{ONE, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE, 0, 0});
		pending_lines.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		queue_random(150);
		set_threshold(16'hFFFF);
		queue_random(150);
		set_threshold(16'd1);
		queue_random(120);
		repeat (3) begin
			set_threshold(THR_W'($urandom));
			queue_random(60);
		end
		wait_idle();
		if (expected_closest.size() > 0) begin
			$error("%0d results never arrived", expected_closest.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/llca_pkg.sv
rtl/llca_mul.sv
rtl/llca_div.sv
rtl/line_line_closest_approach.sv
tb/sv/tb.sv
